/* src/rcmejk_pkg.sv */
// Package for the RCM endoscope joint kinematics unit.
// Holds FSM states, the product microcode, and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package rcmejk_pkg;

    localparam int unsigned CORDIC_ITERS = 16;
    localparam logic [4:0]  LAST_STEP    = 5'd30;

    localparam logic signed [26:0] CORDIC_START = 27'sd10188014;
    localparam logic signed [16:0] HALF_PI_Q13  = 17'sd12868;
    localparam logic signed [16:0] PI_Q13       = 17'sd25736;
    localparam logic signed [17:0] ONE_Q14      = 18'sd16384;

    // Request codes
    localparam logic [1:0] REQ_ADD_YAW   = 2'd0;
    localparam logic [1:0] REQ_ADD_PITCH = 2'd1;
    localparam logic [1:0] REQ_ADD_INS   = 2'd2;
    localparam logic [1:0] REQ_SET_ALL   = 2'd3;

    // Config register indexes
    localparam logic [1:0] CFG_YAW_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_PITCH_LIMIT = 2'd1;
    localparam logic [1:0] CFG_INS_MAX     = 2'd2;

    // Angle selection for the shared CORDIC
    localparam logic [1:0] ANG_YAW   = 2'd0;
    localparam logic [1:0] ANG_PITCH = 2'd1;
    localparam logic [1:0] ANG_ROLL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOAD,
        ST_CITER,
        ST_CSTORE,
        ST_MUL,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_SY,
        OP_CY,
        OP_SP,
        OP_CP,
        OP_SR,
        OP_CR,
        OP_PRD,
        OP_INS
    } opsel_t;

    typedef enum logic [2:0] {
        ACC_NOP,
        ACC_LD,
        ACC_LDN,
        ACC_ADD,
        ACC_SUB
    } accop_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_POS28,
        WR_POS14,
        WR_ROT
    } wrop_t;

    // One microcode step: multiply a*b into the product register, apply
    // acc_op to the previous product, and write the old accumulator out.
    typedef struct packed {
        opsel_t     a_sel;
        opsel_t     b_sel;
        logic       b_one;   // b operand is 1.0 in Q1.14
        accop_t     acc_op;
        wrop_t      wr;
        logic [3:0] dst;
    } ustep_t;

    function automatic ustep_t mk(input opsel_t a, input opsel_t b, input logic one,
                                  input accop_t ac, input wrop_t w, input logic [3:0] d);
        ustep_t s;
        s.a_sel  = a;
        s.b_sel  = b;
        s.b_one  = one;
        s.acc_op = ac;
        s.wr     = w;
        s.dst    = d;
        return s;
    endfunction

    // Rotation result slots: row*3+col. Slot 3 (row 1 col 0) is sp directly.
    function automatic ustep_t ucode(input logic [4:0] step);
        ustep_t s;
        s = mk(OP_SY, OP_SY, 1'b0, ACC_NOP, WR_NONE, 4'd0);
        case (step)
            5'd0:  s = mk(OP_CP,  OP_SY,  1'b0, ACC_NOP, WR_NONE,  4'd0);
            5'd1:  s = mk(OP_PRD, OP_INS, 1'b0, ACC_NOP, WR_NONE,  4'd0);
            5'd2:  s = mk(OP_SP,  OP_INS, 1'b0, ACC_LD,  WR_NONE,  4'd0);
            5'd3:  s = mk(OP_CP,  OP_CY,  1'b0, ACC_LDN, WR_POS28, 4'd0);
            5'd4:  s = mk(OP_PRD, OP_INS, 1'b0, ACC_NOP, WR_POS14, 4'd1);
            5'd5:  s = mk(OP_CP,  OP_SY,  1'b0, ACC_LDN, WR_NONE,  4'd0);
            5'd6:  s = mk(OP_PRD, OP_SY,  1'b1, ACC_NOP, WR_POS28, 4'd2);
            5'd7:  s = mk(OP_CY,  OP_CR,  1'b0, ACC_LDN, WR_NONE,  4'd0);
            5'd8:  s = mk(OP_PRD, OP_SY,  1'b1, ACC_NOP, WR_ROT,   4'd0);
            5'd9:  s = mk(OP_SY,  OP_SP,  1'b0, ACC_LD,  WR_NONE,  4'd0);
            5'd10: s = mk(OP_PRD, OP_SR,  1'b0, ACC_NOP, WR_NONE,  4'd0);
            5'd11: s = mk(OP_CY,  OP_SR,  1'b0, ACC_SUB, WR_NONE,  4'd0);
            5'd12: s = mk(OP_PRD, OP_SY,  1'b1, ACC_NOP, WR_ROT,   4'd1);
            5'd13: s = mk(OP_CR,  OP_SY,  1'b0, ACC_LD,  WR_NONE,  4'd0);
            5'd14: s = mk(OP_PRD, OP_SP,  1'b0, ACC_NOP, WR_NONE,  4'd0);
            5'd15: s = mk(OP_CP,  OP_SR,  1'b0, ACC_ADD, WR_NONE,  4'd0);
            5'd16: s = mk(OP_PRD, OP_SY,  1'b1, ACC_NOP, WR_ROT,   4'd2);
            5'd17: s = mk(OP_CP,  OP_CR,  1'b0, ACC_LDN, WR_NONE,  4'd0);
            5'd18: s = mk(OP_PRD, OP_SY,  1'b1, ACC_NOP, WR_ROT,   4'd4);
            5'd19: s = mk(OP_CP,  OP_CY,  1'b0, ACC_LD,  WR_NONE,  4'd0);
            5'd20: s = mk(OP_PRD, OP_SY,  1'b1, ACC_NOP, WR_ROT,   4'd5);
            5'd21: s = mk(OP_SY,  OP_CR,  1'b0, ACC_LD,  WR_NONE,  4'd0);
            5'd22: s = mk(OP_PRD, OP_SY,  1'b1, ACC_NOP, WR_ROT,   4'd6);
            5'd23: s = mk(OP_CY,  OP_SP,  1'b0, ACC_LD,  WR_NONE,  4'd0);
            5'd24: s = mk(OP_PRD, OP_SR,  1'b0, ACC_NOP, WR_NONE,  4'd0);
            5'd25: s = mk(OP_SY,  OP_SR,  1'b0, ACC_ADD, WR_NONE,  4'd0);
            5'd26: s = mk(OP_PRD, OP_SY,  1'b1, ACC_NOP, WR_ROT,   4'd7);
            5'd27: s = mk(OP_CR,  OP_CY,  1'b0, ACC_LD,  WR_NONE,  4'd0);
            5'd28: s = mk(OP_PRD, OP_SP,  1'b0, ACC_NOP, WR_NONE,  4'd0);
            5'd29: s = mk(OP_SY,  OP_SY,  1'b0, ACC_SUB, WR_NONE,  4'd0);
            5'd30: s = mk(OP_SY,  OP_SY,  1'b0, ACC_NOP, WR_ROT,   4'd8);
            default: s = mk(OP_SY, OP_SY, 1'b0, ACC_NOP, WR_NONE, 4'd0);
        endcase
        return s;
    endfunction

    // atan(2^-i) in Q.16
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:  v = 16'd51472;
            4'd1:  v = 16'd30386;
            4'd2:  v = 16'd16055;
            4'd3:  v = 16'd8150;
            4'd4:  v = 16'd4091;
            4'd5:  v = 16'd2047;
            4'd6:  v = 16'd1024;
            4'd7:  v = 16'd512;
            4'd8:  v = 16'd256;
            4'd9:  v = 16'd128;
            4'd10: v = 16'd64;
            4'd11: v = 16'd32;
            4'd12: v = 16'd16;
            4'd13: v = 16'd8;
            4'd14: v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

/* src/rcm_endoscope_joint_kinematics_unit.sv */
// Top level of the RCM endoscope joint kinematics unit.
// A new input transaction is accepted only in idle, after the previous result has moved to the output register.
// The work is done by one shared CORDIC stage (3 angles in turn) and one
// shared multiplier stepping a 31-step microcode. Depends on rcmejk_pkg.
// Reset (rst_n, async low): joints zero, limits 1.5 rad / 1.5 rad / insertion 49152, no output.
`timescale 1ns / 1ps

module rcm_endoscope_joint_kinematics_unit
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [15:0] delta,
    input  logic signed [15:0] set_yaw,
    input  logic signed [15:0] set_pitch,
    input  logic [15:0]        set_insertion,
    input  logic signed [15:0] set_roll,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] rot_00,
    output logic signed [15:0] rot_01,
    output logic signed [15:0] rot_02,
    output logic signed [15:0] rot_10,
    output logic signed [15:0] rot_11,
    output logic signed [15:0] rot_12,
    output logic signed [15:0] rot_20,
    output logic signed [15:0] rot_21,
    output logic signed [15:0] rot_22,
    // config write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    rcmejk_pkg::state_t state_reg, state_next;

    logic [13:0] yaw_lim_reg, pitch_lim_reg;
    logic [15:0] ins_max_reg;

    // joint state
    logic signed [15:0] yaw_reg, yaw_next;
    logic signed [15:0] pitch_reg, pitch_next;
    logic [15:0]        ins_reg, ins_next;
    logic signed [15:0] roll_reg, roll_next;

    // CORDIC working set
    logic signed [26:0] cx_reg, cx_next;
    logic signed [26:0] cyv_reg, cyv_next;
    logic signed [19:0] cz_reg, cz_next;
    logic               neg_reg, neg_next;
    logic [3:0]         iter_reg, iter_next;
    logic [1:0]         ang_reg, ang_next;

    // sines and cosines, Q1.14
    logic signed [15:0] sy_reg, cy_reg, sp_reg, cp_reg, sr_reg, cr_reg;
    logic signed [15:0] sy_next, cy_next, sp_next, cp_next, sr_next, cr_next;

    // product engine
    logic [4:0]         step_reg, step_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [51:0] acc_reg, acc_next;

    // results being built, and the output holding register
    logic signed [16:0] res_pos_reg [0:2];
    logic signed [15:0] res_rot_reg [0:8];
    logic signed [16:0] out_pos_reg [0:2];
    logic signed [15:0] out_rot_reg [0:8];
    logic               out_valid_reg, out_valid_next;

    logic in_acc, out_take, fin_load;

    assign in_stall = (state_reg != rcmejk_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    // result moves to the output register once the old one is gone or leaving
    assign fin_load = (state_reg == rcmejk_pkg::ST_FIN) && (!out_valid_reg || !out_stall);

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcmejk_pkg::ST_IDLE:
                if (in_valid)
                    state_next = rcmejk_pkg::ST_CLOAD;
            rcmejk_pkg::ST_CLOAD:
                state_next = rcmejk_pkg::ST_CITER;
            rcmejk_pkg::ST_CITER:
                if (iter_reg == 4'(rcmejk_pkg::CORDIC_ITERS - 1))
                    state_next = rcmejk_pkg::ST_CSTORE;
            rcmejk_pkg::ST_CSTORE:
                if (ang_reg == rcmejk_pkg::ANG_ROLL)
                    state_next = rcmejk_pkg::ST_MUL;
                else
                    state_next = rcmejk_pkg::ST_CLOAD;
            rcmejk_pkg::ST_MUL:
                if (step_reg == rcmejk_pkg::LAST_STEP)
                    state_next = rcmejk_pkg::ST_FIN;
            rcmejk_pkg::ST_FIN:
                if (fin_load)
                    state_next = rcmejk_pkg::ST_IDLE;
            default:
                state_next = rcmejk_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Joint update on an accepted transaction (add-and-clamp or set-all)
    // ---------------------------------------------------------------
    logic signed [16:0] yaw_sum, pitch_sum, yaw_src, pitch_src, roll_src;
    logic signed [16:0] yaw_lim_s, pitch_lim_s;
    logic signed [17:0] ins_sum, ins_src, ins_max_s;

    always_comb
    begin
        yaw_lim_s   = $signed({3'b000, yaw_lim_reg});
        pitch_lim_s = $signed({3'b000, pitch_lim_reg});
        ins_max_s   = $signed({2'b00, ins_max_reg});
        yaw_sum     = 17'(yaw_reg) + 17'(delta);
        pitch_sum   = 17'(pitch_reg) + 17'(delta);
        ins_sum     = $signed({2'b00, ins_reg}) + 18'(delta);

        yaw_src   = 17'(yaw_reg);
        pitch_src = 17'(pitch_reg);
        ins_src   = $signed({2'b00, ins_reg});
        roll_src  = 17'(roll_reg);
        unique case (req_type)
            rcmejk_pkg::REQ_ADD_YAW:   yaw_src = yaw_sum;
            rcmejk_pkg::REQ_ADD_PITCH: pitch_src = pitch_sum;
            rcmejk_pkg::REQ_ADD_INS:   ins_src = ins_sum;
            rcmejk_pkg::REQ_SET_ALL:
            begin
                yaw_src   = 17'(set_yaw);
                pitch_src = 17'(set_pitch);
                ins_src   = $signed({2'b00, set_insertion});
                roll_src  = 17'(set_roll);
            end
            default: ;
        endcase

        // untouched joints are already in range, except after a lowered limit,
        // so clamp only the ones this request changes
        yaw_next   = yaw_reg;
        pitch_next = pitch_reg;
        ins_next   = ins_reg;
        roll_next  = roll_reg;
        if (in_acc)
        begin
            if (req_type == rcmejk_pkg::REQ_ADD_YAW || req_type == rcmejk_pkg::REQ_SET_ALL)
            begin
                if (yaw_src > yaw_lim_s)
                    yaw_next = 16'(yaw_lim_s);
                else if (yaw_src < -yaw_lim_s)
                    yaw_next = 16'(-yaw_lim_s);
                else
                    yaw_next = 16'(yaw_src);
            end
            if (req_type == rcmejk_pkg::REQ_ADD_PITCH || req_type == rcmejk_pkg::REQ_SET_ALL)
            begin
                if (pitch_src > pitch_lim_s)
                    pitch_next = 16'(pitch_lim_s);
                else if (pitch_src < -pitch_lim_s)
                    pitch_next = 16'(-pitch_lim_s);
                else
                    pitch_next = 16'(pitch_src);
            end
            if (req_type == rcmejk_pkg::REQ_ADD_INS || req_type == rcmejk_pkg::REQ_SET_ALL)
            begin
                if (ins_src < 18'sd0)
                    ins_next = 16'd0;
                else if (ins_src > ins_max_s)
                    ins_next = ins_max_reg;
                else
                    ins_next = ins_src[15:0];
            end
            if (req_type == rcmejk_pkg::REQ_SET_ALL)
            begin
                if (roll_src > rcmejk_pkg::PI_Q13)
                    roll_next = 16'(rcmejk_pkg::PI_Q13);
                else if (roll_src < -rcmejk_pkg::PI_Q13)
                    roll_next = 16'(-rcmejk_pkg::PI_Q13);
                else
                    roll_next = 16'(roll_src);
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared CORDIC: reduce into +-pi/2, 16 rotation steps, round and clamp
    // ---------------------------------------------------------------
    logic signed [16:0] ang_sel, ang_red;
    logic               ang_neg;
    logic signed [26:0] sh_x, sh_y;
    logic signed [19:0] at_step;
    logic signed [26:0] rx, ry;
    logic signed [16:0] cos_rnd, sin_rnd, cos_cl, sin_cl;
    logic signed [15:0] cos_fin, sin_fin;

    always_comb
    begin
        case (ang_reg)
            rcmejk_pkg::ANG_YAW:   ang_sel = 17'(yaw_reg);
            rcmejk_pkg::ANG_PITCH: ang_sel = 17'(pitch_reg);
            default:               ang_sel = 17'(roll_reg);
        endcase
        ang_neg = 1'b0;
        ang_red = ang_sel;
        if (ang_sel > rcmejk_pkg::HALF_PI_Q13)
        begin
            ang_red = ang_sel - rcmejk_pkg::PI_Q13;
            ang_neg = 1'b1;
        end
        else if (ang_sel < -rcmejk_pkg::HALF_PI_Q13)
        begin
            ang_red = ang_sel + rcmejk_pkg::PI_Q13;
            ang_neg = 1'b1;
        end

        sh_x    = cx_reg >>> iter_reg;
        sh_y    = cyv_reg >>> iter_reg;
        at_step = $signed({4'b0000, rcmejk_pkg::atan_q16(iter_reg)});

        rx      = cx_reg + 27'sd512;
        ry      = cyv_reg + 27'sd512;
        cos_rnd = 17'(rx >>> 10);
        sin_rnd = 17'(ry >>> 10);
        cos_cl  = cos_rnd;
        sin_cl  = sin_rnd;
        if (cos_rnd > 17'sd16384)
            cos_cl = 17'sd16384;
        else if (cos_rnd < -17'sd16384)
            cos_cl = -17'sd16384;
        if (sin_rnd > 17'sd16384)
            sin_cl = 17'sd16384;
        else if (sin_rnd < -17'sd16384)
            sin_cl = -17'sd16384;
        cos_fin = neg_reg ? 16'(-cos_cl) : 16'(cos_cl);
        sin_fin = neg_reg ? 16'(-sin_cl) : 16'(sin_cl);
    end

    // ---------------------------------------------------------------
    // Shared multiplier and accumulator driven by the microcode
    // ---------------------------------------------------------------
    rcmejk_pkg::ustep_t us;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] prod_ext;
    logic signed [51:0] rnd28, rnd14;
    logic signed [23:0] q28, q14;
    logic signed [16:0] pos28_cl, pos14_cl;
    logic signed [15:0] rot_cl;

    function automatic logic signed [15:0] pick(input rcmejk_pkg::opsel_t s,
        input logic signed [15:0] a0, input logic signed [15:0] a1,
        input logic signed [15:0] a2, input logic signed [15:0] a3,
        input logic signed [15:0] a4, input logic signed [15:0] a5);
        logic signed [15:0] v;
        case (s)
            rcmejk_pkg::OP_SY: v = a0;
            rcmejk_pkg::OP_CY: v = a1;
            rcmejk_pkg::OP_SP: v = a2;
            rcmejk_pkg::OP_CP: v = a3;
            rcmejk_pkg::OP_SR: v = a4;
            default:           v = a5;
        endcase
        return v;
    endfunction

    always_comb
    begin
        us = rcmejk_pkg::ucode(step_reg);

        if (us.a_sel == rcmejk_pkg::OP_PRD)
            mul_a = prod_reg[32:0];
        else
            mul_a = 33'(pick(us.a_sel, sy_reg, cy_reg, sp_reg, cp_reg, sr_reg, cr_reg));

        if (us.b_one)
            mul_b = rcmejk_pkg::ONE_Q14;
        else if (us.b_sel == rcmejk_pkg::OP_INS)
            mul_b = $signed({2'b00, ins_reg});
        else
            mul_b = 18'(pick(us.b_sel, sy_reg, cy_reg, sp_reg, cp_reg, sr_reg, cr_reg));

        prod_ext = 52'(prod_reg);

        // round half up on the accumulator, then clamp per output kind
        rnd28 = acc_reg + 52'sd134217728;
        rnd14 = acc_reg + 52'sd8192;
        q28   = 24'(rnd28 >>> 28);
        q14   = 24'(rnd14 >>> 14);
        if (q28 > 24'sd65535)
            pos28_cl = 17'sd65535;
        else if (q28 < -24'sd65535)
            pos28_cl = -17'sd65535;
        else
            pos28_cl = 17'(q28);
        if (q14 > 24'sd65535)
            pos14_cl = 17'sd65535;
        else if (q14 < -24'sd65535)
            pos14_cl = -17'sd65535;
        else
            pos14_cl = 17'(q14);
        if (q28 > 24'sd16384)
            rot_cl = 16'sd16384;
        else if (q28 < -24'sd16384)
            rot_cl = -16'sd16384;
        else
            rot_cl = 16'(q28);
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb
    begin
        cx_next   = cx_reg;
        cyv_next  = cyv_reg;
        cz_next   = cz_reg;
        neg_next  = neg_reg;
        iter_next = iter_reg;
        ang_next  = ang_reg;
        sy_next   = sy_reg;
        cy_next   = cy_reg;
        sp_next   = sp_reg;
        cp_next   = cp_reg;
        sr_next   = sr_reg;
        cr_next   = cr_reg;
        step_next = step_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;

        unique case (state_reg)
            rcmejk_pkg::ST_IDLE:
            begin
                ang_next  = rcmejk_pkg::ANG_YAW;
                step_next = 5'd0;
            end
            rcmejk_pkg::ST_CLOAD:
            begin
                cx_next   = rcmejk_pkg::CORDIC_START;
                cyv_next  = 27'sd0;
                cz_next   = 20'(ang_red) <<< 3;
                neg_next  = ang_neg;
                iter_next = 4'd0;
            end
            rcmejk_pkg::ST_CITER:
            begin
                if (!cz_reg[19])
                begin
                    cx_next  = cx_reg - sh_y;
                    cyv_next = cyv_reg + sh_x;
                    cz_next  = cz_reg - at_step;
                end
                else
                begin
                    cx_next  = cx_reg + sh_y;
                    cyv_next = cyv_reg - sh_x;
                    cz_next  = cz_reg + at_step;
                end
                iter_next = iter_reg + 4'd1;
            end
            rcmejk_pkg::ST_CSTORE:
            begin
                case (ang_reg)
                    rcmejk_pkg::ANG_YAW:
                    begin
                        sy_next = sin_fin;
                        cy_next = cos_fin;
                    end
                    rcmejk_pkg::ANG_PITCH:
                    begin
                        sp_next = sin_fin;
                        cp_next = cos_fin;
                    end
                    default:
                    begin
                        sr_next = sin_fin;
                        cr_next = cos_fin;
                    end
                endcase
                ang_next = ang_reg + 2'd1;
            end
            rcmejk_pkg::ST_MUL:
            begin
                prod_next = 51'(mul_a) * 51'(mul_b);
                case (us.acc_op)
                    rcmejk_pkg::ACC_LD:  acc_next = prod_ext;
                    rcmejk_pkg::ACC_LDN: acc_next = -prod_ext;
                    rcmejk_pkg::ACC_ADD: acc_next = acc_reg + prod_ext;
                    rcmejk_pkg::ACC_SUB: acc_next = acc_reg - prod_ext;
                    default:             acc_next = acc_reg;
                endcase
                step_next = step_reg + 5'd1;
            end
            rcmejk_pkg::ST_FIN: ;
            default: ;
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_take)
            out_valid_next = 1'b0;
        if (fin_load)
            out_valid_next = 1'b1;
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcmejk_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            yaw_lim_reg   <= 14'd12288;
            pitch_lim_reg <= 14'd12288;
            ins_max_reg   <= 16'd49152;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            ins_reg       <= '0;
            roll_reg      <= '0;
            iter_reg      <= '0;
            ang_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            yaw_reg       <= yaw_next;
            pitch_reg     <= pitch_next;
            ins_reg       <= ins_next;
            roll_reg      <= roll_next;
            iter_reg      <= iter_next;
            ang_reg       <= ang_next;
            step_reg      <= step_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rcmejk_pkg::CFG_YAW_LIMIT:   yaw_lim_reg   <= cfg_data[13:0];
                    rcmejk_pkg::CFG_PITCH_LIMIT: pitch_lim_reg <= cfg_data[13:0];
                    rcmejk_pkg::CFG_INS_MAX:     ins_max_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cyv_reg  <= cyv_next;
        cz_reg   <= cz_next;
        neg_reg  <= neg_next;
        sy_reg   <= sy_next;
        cy_reg   <= cy_next;
        sp_reg   <= sp_next;
        cp_reg   <= cp_next;
        sr_reg   <= sr_next;
        cr_reg   <= cr_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;

        if (state_reg == rcmejk_pkg::ST_MUL)
        begin
            case (us.wr)
                rcmejk_pkg::WR_POS28: res_pos_reg[us.dst[1:0]] <= pos28_cl;
                rcmejk_pkg::WR_POS14: res_pos_reg[us.dst[1:0]] <= pos14_cl;
                rcmejk_pkg::WR_ROT:   res_rot_reg[us.dst]      <= rot_cl;
                default: ;
            endcase
        end
        if (state_reg == rcmejk_pkg::ST_CSTORE && ang_reg == rcmejk_pkg::ANG_PITCH)
            res_rot_reg[3] <= sin_fin;  // row 1 col 0 is sin(pitch) itself

        if (fin_load)
        begin
            out_pos_reg <= res_pos_reg;
            out_rot_reg <= res_rot_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x  = out_pos_reg[0];
    assign pos_y  = out_pos_reg[1];
    assign pos_z  = out_pos_reg[2];
    assign rot_00 = out_rot_reg[0];
    assign rot_01 = out_rot_reg[1];
    assign rot_02 = out_rot_reg[2];
    assign rot_10 = out_rot_reg[3];
    assign rot_11 = out_rot_reg[4];
    assign rot_12 = out_rot_reg[5];
    assign rot_20 = out_rot_reg[6];
    assign rot_21 = out_rot_reg[7];
    assign rot_22 = out_rot_reg[8];

endmodule
